>>> src/jhps_pkg.sv
// shared types and constants of the jacobi heat plate sweep unit
// payload structs, operation and status codes, configuration register indexes
package jhps_pkg;

    localparam int TEMP_BITS  = 24;
    localparam int OP_W       = 2;
    localparam int COORD_W    = 5;
    localparam int CNT_W      = 16;
    localparam int ST_W       = 3;
    localparam int GS_W       = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [TEMP_BITS-1:0] t_temp;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_SWEEP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_CORNER   = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [ST_W-1:0] ST_LIMIT    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_INIT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_TEMP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_TEMP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TEMP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TEMP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_TEMP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_PINNED = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] cell_value;
        logic [CNT_W-1:0]            sweeps_done;
        logic [ST_W-1:0]             status;
    } t_out_item;

endpackage

>>> src/jacobi_heat_plate_sweep_unit.sv
// jacobi heat plate sweep unit: two grid banks in ram, one cell per cycle.
// one item in flight; a sweep streams the source bank through its single read
// port, one cell per cycle, SIDE columns per row.
// reset clears control and config; grid banks are not cleared, so every sweep
// or read before the first init answers not-initialized.
module jacobi_heat_plate_sweep_unit #(
    parameter int MAX_INTERIOR = 30
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  jhps_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output jhps_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [jhps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jhps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import jhps_pkg::*;

    localparam int SIDE  = MAX_INTERIOR + 2;
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(SIDE + 1);
    localparam int CW    = $clog2(SIDE);
    localparam int XW    = ((RW > COORD_W) ? RW : COORD_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INIT  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // configuration registers
    logic [GS_W-1:0]  r_cfg_grid_size;
    logic [CNT_W-1:0] r_cfg_limit;
    t_temp            r_cfg_top, r_cfg_bottom, r_cfg_left, r_cfg_right, r_cfg_center;
    logic             r_cfg_pinned;

    // control state
    t_state           r_state, n_state;
    logic [RW-1:0]    r_held_n, n_held_n;
    logic             r_held_pin, n_held_pin;
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_loaded, n_loaded;
    logic [RW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_rd_on, n_rd_on;
    t_out_item        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    // read pipeline stage of the sweep
    logic             r_p_valid;
    logic [RW-1:0]    r_p_row;
    logic [CW-1:0]    r_p_col;
    logic [AW-1:0]    r_p_addr;

    // ram ports
    logic             we_a, we_b;
    logic [AW-1:0]    waddr_a, waddr_b, raddr;
    t_temp            wdata_a, wdata_b, rdata_a, rdata_b, rdata_src;

    logic [RW-1:0]    n1, n2, mid, kr;
    logic             col_last;
    logic [XW-1:0]    gs_x, clamp_x, row_x, col_x, n1_x, mid_x, in_row_x, in_col_x;
    logic [XW-1:0]    kr_x, kc_x;
    logic [2*XW-1:0]  lin;
    t_temp            init_val, sweep_val, win_center, win_mean;
    logic             k_fixed, k_write;
    logic [AW-1:0]    k_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_grid_size <= GS_W'(1);
            r_cfg_limit     <= '0;
            r_cfg_top       <= '0;
            r_cfg_bottom    <= '0;
            r_cfg_left      <= '0;
            r_cfg_right     <= '0;
            r_cfg_center    <= '0;
            r_cfg_pinned    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_SIZE:     r_cfg_grid_size <= i_cfg_data[GS_W-1:0];
                CFG_ITER_LIMIT:    r_cfg_limit     <= i_cfg_data[CNT_W-1:0];
                CFG_TOP_TEMP:      r_cfg_top       <= i_cfg_data[TEMP_BITS-1:0];
                CFG_BOTTOM_TEMP:   r_cfg_bottom    <= i_cfg_data[TEMP_BITS-1:0];
                CFG_LEFT_TEMP:     r_cfg_left      <= i_cfg_data[TEMP_BITS-1:0];
                CFG_RIGHT_TEMP:    r_cfg_right     <= i_cfg_data[TEMP_BITS-1:0];
                CFG_CENTER_TEMP:   r_cfg_center    <= i_cfg_data[TEMP_BITS-1:0];
                CFG_CENTER_PINNED: r_cfg_pinned    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // grid geometry
    always_comb begin
        n1       = r_held_n + RW'(1);
        n2       = r_held_n + RW'(2);
        mid      = n1 >> 1;
        n1_x     = XW'(n1);
        mid_x    = XW'(mid);
        row_x    = XW'(r_row);
        col_x    = XW'(r_col);
        col_last = (r_col == CW'(SIDE - 1));
        gs_x     = XW'(r_cfg_grid_size);
        if (gs_x == '0) begin
            clamp_x = XW'(1);
        end else if (gs_x > XW'(MAX_INTERIOR)) begin
            clamp_x = XW'(MAX_INTERIOR);
        end else begin
            clamp_x = gs_x;
        end
        in_row_x = XW'(i_in_data.cell_row);
        in_col_x = XW'(i_in_data.cell_col);
        lin      = {{XW{1'b0}}, in_row_x} * (2*XW)'(SIDE) + {{XW{1'b0}}, in_col_x};
    end

    // border and pinned-center values written during init
    always_comb begin
        if ((row_x == '0 || row_x == n1_x) && (col_x == '0 || col_x == n1_x)) begin
            init_val = '0;
        end else if (row_x == '0) begin
            init_val = r_cfg_top;
        end else if (row_x == n1_x) begin
            init_val = r_cfg_bottom;
        end else if (col_x == '0) begin
            init_val = r_cfg_left;
        end else if (col_x == n1_x) begin
            init_val = r_cfg_right;
        end else if (r_held_pin && row_x == mid_x && col_x == mid_x) begin
            init_val = r_cfg_center;
        end else begin
            init_val = '0;
        end
    end

    // the cell being written is one row behind the read pipeline stage
    always_comb begin
        kr      = r_p_row - RW'(1);
        kr_x    = XW'(kr);
        kc_x    = XW'(r_p_col);
        k_addr  = r_p_addr - AW'(SIDE);
        k_write = r_p_valid && (r_p_row != '0);
        k_fixed = (kr_x == '0) || (kr_x == n1_x) || (kc_x == '0) || (kc_x >= n1_x)
                || (r_held_pin && kr_x == mid_x && kc_x == mid_x);
        sweep_val = k_fixed ? win_center : win_mean;
    end

    always_comb begin
        we_a    = (r_state == S_INIT) || (k_write && r_bank);
        we_b    = k_write && !r_bank;
        waddr_a = (r_state == S_INIT) ? r_addr : k_addr;
        wdata_a = (r_state == S_INIT) ? init_val : sweep_val;
        waddr_b = k_addr;
        wdata_b = sweep_val;
        raddr   = (r_state == S_IDLE) ? lin[AW-1:0] : r_addr;
        rdata_src = r_bank ? rdata_b : rdata_a;
    end

    jhps_ram #(.WIDTH(TEMP_BITS), .DEPTH(DEPTH)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (wdata_a),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    jhps_ram #(.WIDTH(TEMP_BITS), .DEPTH(DEPTH)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (wdata_b),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    jhps_window #(.SIDE(SIDE)) u_window (
        .i_clk    (i_clk),
        .i_shift  (r_p_valid),
        .i_south  (rdata_src),
        .o_center (win_center),
        .o_mean   (win_mean)
    );

    always_comb begin
        n_state     = r_state;
        n_held_n    = r_held_n;
        n_held_pin  = r_held_pin;
        n_bank      = r_bank;
        n_count     = r_count;
        n_loaded    = r_loaded;
        n_row       = r_row;
        n_col       = r_col;
        n_addr      = r_addr;
        n_rd_on     = r_rd_on;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.cell_value  = '0;
                    n_res.sweeps_done = r_count;
                    n_res.status      = ST_OK;
                    n_row             = '0;
                    n_col             = '0;
                    n_addr            = '0;
                    case (i_in_data.operation)
                        OP_INIT: begin
                            n_held_n   = clamp_x[RW-1:0];
                            n_held_pin = r_cfg_pinned && clamp_x[0];
                            n_state    = S_INIT;
                        end
                        OP_SWEEP: begin
                            if (!r_loaded) begin
                                n_res.status = ST_NOT_INIT;
                                n_state      = S_DONE;
                            end else if (r_count >= r_cfg_limit) begin
                                n_res.status = ST_LIMIT;
                                n_state      = S_DONE;
                            end else begin
                                n_rd_on = 1'b1;
                                n_state = S_SWEEP;
                            end
                        end
                        OP_READ: begin
                            if (!r_loaded) begin
                                n_res.status = ST_NOT_INIT;
                                n_state      = S_DONE;
                            end else if (in_row_x > n1_x || in_col_x > n1_x) begin
                                n_res.status = ST_RANGE;
                                n_state      = S_DONE;
                            end else if ((in_row_x == '0 || in_row_x == n1_x)
                                      && (in_col_x == '0 || in_col_x == n1_x)) begin
                                n_res.status = ST_CORNER;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                n_col  = col_last ? '0 : r_col + CW'(1);
                n_row  = col_last ? r_row + RW'(1) : r_row;
                n_addr = r_addr + AW'(1);
                if (col_last && r_row == n1) begin
                    n_loaded          = 1'b1;
                    n_bank            = 1'b0;
                    n_count           = '0;
                    n_res.cell_value  = '0;
                    n_res.sweeps_done = '0;
                    n_res.status      = ST_OK;
                    n_state           = S_DONE;
                end
            end
            S_SWEEP: begin
                if (r_rd_on) begin
                    n_col  = col_last ? '0 : r_col + CW'(1);
                    n_row  = col_last ? r_row + RW'(1) : r_row;
                    n_addr = r_addr + AW'(1);
                    if (col_last && r_row == n2) begin
                        n_rd_on = 1'b0;
                    end
                end
                // last cell of the extra row has gone through the window
                if (r_p_valid && r_p_row == n2 && r_p_col == CW'(SIDE - 1)) begin
                    n_bank            = !r_bank;
                    n_count           = r_count + CNT_W'(1);
                    n_res.cell_value  = '0;
                    n_res.sweeps_done = r_count + CNT_W'(1);
                    n_res.status      = ST_OK;
                    n_state           = S_DONE;
                end
            end
            S_READ: begin
                n_res.cell_value  = rdata_src;
                n_res.sweeps_done = r_count;
                n_res.status      = ST_OK;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held_n    <= RW'(1);
            r_held_pin  <= 1'b0;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_loaded    <= 1'b0;
            r_rd_on     <= 1'b0;
            r_out_valid <= 1'b0;
            r_p_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held_n    <= n_held_n;
            r_held_pin  <= n_held_pin;
            r_bank      <= n_bank;
            r_count     <= n_count;
            r_loaded    <= n_loaded;
            r_rd_on     <= n_rd_on;
            r_out_valid <= n_out_valid;
            r_p_valid   <= (r_state == S_SWEEP) && r_rd_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_addr   <= n_addr;
        r_res    <= n_res;
        r_out    <= n_out;
        r_p_row  <= r_row;
        r_p_col  <= r_col;
        r_p_addr <= r_addr;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the two banks are never written in the same cycle
    a_bank_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we_a && we_b))
        else $error("both grid banks written in one cycle");

    // a transfer with an error status carries a zero temperature
    a_zero_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.cell_value == '0))
        else $error("nonzero cell value with error status");

    // the read pipeline only runs inside a sweep
    a_pipe_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_state == S_SWEEP))
        else $error("sweep pipeline active outside a sweep");

    // a finished sweep advances the count by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && n_state == S_DONE) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("sweep count did not advance by one");

endmodule

>>> src/jhps_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module jhps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/jhps_window.sv
// raster-order shift line over two grid rows plus the four-point floored mean
// depends on jhps_pkg
module jhps_window #(
    parameter int SIDE = 32
) (
    input  logic           i_clk,
    input  logic           i_shift,
    input  jhps_pkg::t_temp i_south,
    output jhps_pkg::t_temp o_center,
    output jhps_pkg::t_temp o_mean
);
    import jhps_pkg::*;

    t_temp r_tap [2*SIDE];
    logic signed [TEMP_BITS+1:0] sum;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tap[0] <= i_south;
            for (int j = 1; j < 2*SIDE; j++) begin
                r_tap[j] <= r_tap[j-1];
            end
        end
    end

    // newest read is the south neighbour, taps one and two rows back give
    // the center row and the north neighbour
    always_comb begin
        sum = (TEMP_BITS+2)'(i_south) + (TEMP_BITS+2)'(r_tap[2*SIDE-1])
            + (TEMP_BITS+2)'(r_tap[SIDE]) + (TEMP_BITS+2)'(r_tap[SIDE-2]);
    end

    assign o_center = r_tap[SIDE-1];
    // floor divide by four: drop the two low bits of the signed sum
    assign o_mean   = sum[TEMP_BITS+1:2];

endmodule

>>> sim/jhps_plate_checker.sv
// plate checker for the jacobi heat plate sweep unit: watches config writes and both channels
// keeps its own two-bank copy of the plate, predicts each result and compares; needs jhps_pkg
module jhps_plate_checker
    import jhps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_failures,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int MAX_INTERIOR = 30;
    localparam int SIDE         = MAX_INTERIOR + 2;
    localparam int CELLS        = SIDE * SIDE;

    // register copies
    logic [GS_W-1:0]  size_reg;
    logic [CNT_W-1:0] limit_reg;
    t_temp            top_reg, bottom_reg, left_reg, right_reg, center_reg;
    logic             pin_reg;

    // plate state
    t_temp            plate [0:1][0:CELLS-1];
    logic             cur_bank;
    logic [CNT_W-1:0] sweep_cnt;
    logic             loaded;
    int               held_n;
    logic             held_pin;

    t_out_item        expected_q [$];
    int               failures = 0;
    int               checked  = 0;

    task automatic report_mismatch(input string msg);
        if (failures < 100)
            $display("%0t mismatch: %s", $realtime, msg);
        failures++;
    endtask

    function automatic void load_plate();
        int    n;
        int    mid;
        t_temp v;
        n = int'(size_reg);
        if (n < 1) n = 1;
        if (n > MAX_INTERIOR) n = MAX_INTERIOR;
        held_n   = n;
        held_pin = pin_reg && (n % 2 == 1);
        mid      = (n + 1) / 2;
        for (int r = 0; r < n + 2; r++) begin
            for (int c = 0; c < n + 2; c++) begin
                if ((r == 0 || r == n + 1) && (c == 0 || c == n + 1))
                    v = '0;
                else if (r == 0)
                    v = top_reg;
                else if (r == n + 1)
                    v = bottom_reg;
                else if (c == 0)
                    v = left_reg;
                else if (c == n + 1)
                    v = right_reg;
                else if (held_pin && r == mid && c == mid)
                    v = center_reg;
                else
                    v = '0;
                plate[0][r*SIDE+c] = v;
            end
        end
        cur_bank  = 1'b0;
        sweep_cnt = '0;
        loaded    = 1'b1;
    endfunction

    function automatic void sweep_plate();
        int                          i;
        int                          mid;
        bit                          fixed;
        logic signed [TEMP_BITS+1:0] total;
        logic signed [TEMP_BITS+1:0] mean;
        mid = (held_n + 1) / 2;
        for (int r = 0; r < held_n + 2; r++) begin
            for (int c = 0; c < held_n + 2; c++) begin
                i = r * SIDE + c;
                fixed = (r == 0 || c == 0 || r == held_n + 1 || c == held_n + 1) ||
                        (held_pin && r == mid && c == mid);
                if (fixed) begin
                    plate[cur_bank ^ 1'b1][i] = plate[cur_bank][i];
                end else begin
                    total = plate[cur_bank][i-SIDE] + plate[cur_bank][i+SIDE]
                          + plate[cur_bank][i-1] + plate[cur_bank][i+1];
                    // arithmetic shift floors toward minus infinity
                    mean = total >>> 2;
                    plate[cur_bank ^ 1'b1][i] = mean[TEMP_BITS-1:0];
                end
            end
        end
        cur_bank  = cur_bank ^ 1'b1;
        sweep_cnt = sweep_cnt + 1'b1;
    endfunction

    function automatic t_out_item predict_result(input t_in_item item);
        t_out_item res;
        int        row;
        int        col;
        row            = int'(item.cell_row);
        col            = int'(item.cell_col);
        res.cell_value = '0;
        res.status     = ST_OK;
        case (item.operation)
            OP_INIT: begin
                load_plate();
            end
            OP_SWEEP: begin
                if (!loaded)
                    res.status = ST_NOT_INIT;
                else if (sweep_cnt >= limit_reg)
                    res.status = ST_LIMIT;
                else
                    sweep_plate();
            end
            OP_READ: begin
                if (!loaded)
                    res.status = ST_NOT_INIT;
                else if (row > held_n + 1 || col > held_n + 1)
                    res.status = ST_RANGE;
                else if ((row == 0 || row == held_n + 1) && (col == 0 || col == held_n + 1))
                    res.status = ST_CORNER;
                else
                    res.cell_value = plate[cur_bank][row*SIDE+col];
            end
            default: ;
        endcase
        res.sweeps_done = sweep_cnt;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            size_reg   = 5'd1;
            limit_reg  = '0;
            top_reg    = '0;
            bottom_reg = '0;
            left_reg   = '0;
            right_reg  = '0;
            center_reg = '0;
            pin_reg    = 1'b0;
            cur_bank   = 1'b0;
            sweep_cnt  = '0;
            loaded     = 1'b0;
            held_n     = 1;
            held_pin   = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_SIZE:     size_reg   = i_cfg_data[GS_W-1:0];
                    CFG_ITER_LIMIT:    limit_reg  = i_cfg_data[CNT_W-1:0];
                    CFG_TOP_TEMP:      top_reg    = i_cfg_data[TEMP_BITS-1:0];
                    CFG_BOTTOM_TEMP:   bottom_reg = i_cfg_data[TEMP_BITS-1:0];
                    CFG_LEFT_TEMP:     left_reg   = i_cfg_data[TEMP_BITS-1:0];
                    CFG_RIGHT_TEMP:    right_reg  = i_cfg_data[TEMP_BITS-1:0];
                    CFG_CENTER_TEMP:   center_reg = i_cfg_data[TEMP_BITS-1:0];
                    CFG_CENTER_PINNED: pin_reg    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", i_out_data));
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (i_out_data.cell_value !== want.cell_value)
                        report_mismatch($sformatf("cell_value got %0d expected %0d",
                                        i_out_data.cell_value, want.cell_value));
                    if (i_out_data.sweeps_done !== want.sweeps_done)
                        report_mismatch($sformatf("sweeps_done got %0d expected %0d",
                                        i_out_data.sweeps_done, want.sweeps_done));
                    if (i_out_data.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                        i_out_data.status, want.status));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(predict_result(i_in_data));
        end
        o_pending  <= expected_q.size();
        o_failures <= failures;
        o_checked  <= checked;
    end

endmodule

>>> sim/jacobi_heat_plate_sweep_unit_tb.sv
// testbench top for the jacobi heat plate sweep unit: clock, reset, register writes and items
// relies on jhps_pkg, the unit itself and jhps_plate_checker for prediction and comparison
module jacobi_heat_plate_sweep_unit_tb;
    import jhps_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF    = 2'd3;
    localparam int              CYCLE_LIMIT = 4_000_000;
    localparam int              PHASES      = 12;
    localparam int              PHASE_ITEMS = 44;

    localparam logic [TEMP_BITS-1:0] TEMP_MAX = 24'h7FFFFF;
    localparam logic [TEMP_BITS-1:0] TEMP_MIN = 24'h800000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int failures;
    int pending;
    int checked;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int items_sent  = 0;
    int cfg_n       = 1;
    int grid_n      = 1;

    jacobi_heat_plate_sweep_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    jhps_plate_checker checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
            $display("[jacobi_heat_plate_sweep_unit] ERROR");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct <= 0;  end
            1: begin gap_pct = 57; stall_pct <= 0;  end
            2: begin gap_pct = 0;  stall_pct <= 57; end
            default: begin gap_pct = 36; stall_pct <= 36; end
        endcase
    endtask

    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (item.operation == OP_INIT)
            grid_n = cfg_n;
        items_sent++;
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input int row, input int col);
        t_in_item item;
        item.operation = op;
        item.cell_row  = COORD_W'(row);
        item.cell_col  = COORD_W'(col);
        send_item(item);
    endtask

    // drop valid and let every outstanding result come back before touching registers
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_plate(input int size, input int limit,
                                 input logic [TEMP_BITS-1:0] t_top, input logic [TEMP_BITS-1:0] t_bot,
                                 input logic [TEMP_BITS-1:0] t_left,
                                 input logic [TEMP_BITS-1:0] t_right,
                                 input logic [TEMP_BITS-1:0] t_center, input logic pin);
        wait_drained();
        write_reg(CFG_GRID_SIZE, CFG_DATA_W'(size));
        write_reg(CFG_ITER_LIMIT, CFG_DATA_W'(limit));
        write_reg(CFG_TOP_TEMP, t_top);
        write_reg(CFG_BOTTOM_TEMP, t_bot);
        write_reg(CFG_LEFT_TEMP, t_left);
        write_reg(CFG_RIGHT_TEMP, t_right);
        write_reg(CFG_CENTER_TEMP, t_center);
        write_reg(CFG_CENTER_PINNED, CFG_DATA_W'(pin));
        cfg_we <= 1'b0;
        cfg_n = (size < 1) ? 1 : (size > 30) ? 30 : size;
    endtask

    function automatic logic [TEMP_BITS-1:0] rand_temp();
        int k;
        k = $urandom_range(99);
        if (k < 12) return TEMP_MAX;
        if (k < 24) return TEMP_MIN;
        if (k < 32) return '0;
        return TEMP_BITS'($urandom);
    endfunction

    function automatic t_in_item read_item();
        t_in_item item;
        int       k;
        item.operation = OP_READ;
        k = $urandom_range(99);
        if (k < 70) begin
            item.cell_row = COORD_W'($urandom_range(grid_n + 1));
            item.cell_col = COORD_W'($urandom_range(grid_n + 1));
        end else if (k < 80) begin
            item.cell_row = COORD_W'($urandom_range(1) ? grid_n + 1 : 0);
            item.cell_col = COORD_W'($urandom_range(1) ? grid_n + 1 : 0);
        end else begin
            item.cell_row = COORD_W'($urandom_range(31));
            item.cell_col = COORD_W'($urandom_range(31));
        end
        return item;
    endfunction

    initial begin
        int size;
        int limit;
        int k;
        t_in_item item;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any init, with reset register values
        set_idling(0);
        send_op(OP_SWEEP, 0, 0);
        send_op(OP_READ, 1, 1);
        send_op(OP_UNDEF, 0, 0);
        send_op(OP_INIT, 0, 0);
        send_op(OP_SWEEP, 0, 0);

        // single cell, size zero taken as one, pinned center, extreme borders
        program_plate(0, 2, TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN, 24'h123456, 1'b1);
        send_op(OP_INIT, 0, 0);
        send_op(OP_READ, 1, 1);
        send_op(OP_SWEEP, 0, 0);
        send_op(OP_SWEEP, 0, 0);
        send_op(OP_SWEEP, 0, 0);
        send_op(OP_READ, 0, 1);
        send_op(OP_READ, 1, 0);
        send_op(OP_READ, 0, 0);
        send_op(OP_READ, 2, 2);
        send_op(OP_READ, 3, 1);
        send_op(OP_READ, 1, 31);
        send_op(OP_UNDEF, 31, 31);

        // oversize taken as the largest grid, pin ignored on even size
        program_plate(31, 3, TEMP_MIN, TEMP_MAX, 24'h000001, 24'hFFFFFF, TEMP_MAX, 1'b1);
        send_op(OP_INIT, 0, 0);
        send_op(OP_SWEEP, 0, 0);
        send_op(OP_SWEEP, 0, 0);
        send_op(OP_READ, 1, 1);
        send_op(OP_READ, 15, 15);
        send_op(OP_READ, 31, 30);
        send_op(OP_READ, 31, 31);
        send_op(OP_READ, 30, 30);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 5 || phase == 10)
                size = 30 + $urandom_range(1);
            else if ($urandom_range(3) == 0)
                size = $urandom_range(8, 16);
            else
                size = $urandom_range(0, 7);
            k = $urandom_range(2);
            if (size >= 30)
                limit = $urandom_range(0, 3);
            else if (k == 0)
                limit = $urandom_range(0, 20);
            else if (k == 1)
                limit = 65535;
            else
                limit = $urandom_range(65535);
            program_plate(size, limit, rand_temp(), rand_temp(), rand_temp(), rand_temp(),
                          rand_temp(), 1'($urandom_range(1)));
            set_idling(phase % 4);
            send_op(OP_INIT, $urandom_range(31), $urandom_range(31));
            repeat (PHASE_ITEMS) begin
                k = $urandom_range(99);
                if (k < 30) begin
                    send_op(OP_SWEEP, $urandom_range(31), $urandom_range(31));
                end else if (k < 85) begin
                    send_item(read_item());
                end else if (k < 90) begin
                    send_op(OP_UNDEF, $urandom_range(31), $urandom_range(31));
                end else if (k < 95) begin
                    send_op(OP_INIT, $urandom_range(31), $urandom_range(31));
                end else begin
                    item.operation = OP_W'($urandom_range(3));
                    item.cell_row  = COORD_W'($urandom_range(31));
                    item.cell_col  = COORD_W'($urandom_range(31));
                    send_item(item);
                end
            end
        end

        wait_drained();
        $display("%0d items over %0d register settings, %0d results checked in %0d cycles",
                 items_sent, PHASES + 3, checked, cycle_count);
        $display("sizes from one cell to the full plate, with sender gaps and receiver stalls");
        if (failures == 0 && pending == 0) begin
            $display("[jacobi_heat_plate_sweep_unit] OK");
        end else begin
            $display("[jacobi_heat_plate_sweep_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/jhps_pkg.sv
src/jhps_ram.sv
src/jhps_window.sv
src/jacobi_heat_plate_sweep_unit.sv
sim/jhps_plate_checker.sv
sim/jacobi_heat_plate_sweep_unit_tb.sv
